// ----- hw/rtl/sfc_pkg.sv -----
package sfc_pkg;

  localparam int MAX_EVENTS    = 32;
  localparam int SEND_COST     = 1;
  localparam int RECEIVER_LATE = 250;

  localparam int IDX_W = $clog2(MAX_EVENTS);
  localparam int CNT_W = $clog2(MAX_EVENTS + 1);
  localparam int T_W   = 34;
  localparam int NUM_W = 17;
  localparam int DEN_W = 10;

  typedef enum logic [1:0] {
    CAUSE_NONE   = 2'd0,
    CAUSE_FULL   = 2'd1,
    CAUSE_WINDOW = 2'd2,
    CAUSE_SLOT   = 2'd3
  } cause_t;

  typedef enum logic [2:0] {
    CFG_AUDIO_MODE   = 3'd0,
    CFG_WINDOW       = 3'd1,
    CFG_BUDGET_AUDIO = 3'd2,
    CFG_BUDGET_NO    = 3'd3,
    CFG_LOOKAHEAD    = 3'd4,
    CFG_RETRY        = 3'd5,
    CFG_LAST_LEAD    = 3'd6,
    CFG_RX_BUDGET    = 3'd7
  } cfg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INS,
    ST_CHECK,
    ST_WLOAD,
    ST_WCMP,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_SLOAD,
    ST_READY,
    ST_RSTEP,
    ST_REND,
    ST_PICK,
    ST_SEND,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic signed [31:0]  at;
    logic signed [T_W-1:0] last;
    logic [7:0]          owed;
    logic [1:0]          marks;
  } entry_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    entry_t           data;
  } wr_req_t;

  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [NUM_W-1:0] quo;
  } div_resp_t;

endpackage

// ----- hw/rtl/sfc_div.sv -----
module sfc_div (
  input  logic               clk,
  input  logic               rst,
  input  sfc_pkg::div_req_t  req,
  output sfc_pkg::div_resp_t resp
);

  logic                      busy;
  logic [4:0]                cnt;
  logic [sfc_pkg::DEN_W:0]   rem;
  logic [sfc_pkg::NUM_W-1:0] acc;
  logic [sfc_pkg::DEN_W-1:0] den;
  logic                      done;
  logic [sfc_pkg::DEN_W:0]   rem_sh;
  logic                      ge;

  assign rem_sh = {rem[sfc_pkg::DEN_W-1:0], acc[sfc_pkg::NUM_W-1]};
  assign ge     = rem_sh >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 5'd1;
        if (cnt == 5'(sfc_pkg::NUM_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      acc <= req.num;
      den <= req.den;
      rem <= '0;
    end else if (busy) begin
      rem <= ge ? rem_sh - {1'b0, den} : rem_sh;
      acc <= {acc[sfc_pkg::NUM_W-2:0], ge};
    end
  end

  assign resp.done = done;
  assign resp.quo  = acc;

endmodule

// ----- hw/rtl/sfc_store.sv -----
module sfc_store (
  input  logic                        clk,
  input  sfc_pkg::wr_req_t            wr,
  input  logic [sfc_pkg::IDX_W-1:0]   rd_addr,
  output sfc_pkg::entry_t             rd
);

  sfc_pkg::entry_t mem [sfc_pkg::MAX_EVENTS];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  assign rd = mem[rd_addr];

endmodule

// ----- hw/rtl/send_capacity_feasibility_check_top.sv -----
// load: the word is registered, then the insertion walk shifts up to 31 stored words
// check on the last word: a check state, then a window walk over the events that advances
// the window start as needed, then the divider; per owed send one scan over the events
// (with a receiver walk over all events per probe) and a send state
// one word in flight at a time; a result not yet taken holds the block after its check
// synchronous active-high reset clears the store count, overflow mark and
// output valid, and loads the default register values

module send_capacity_feasibility_check_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] execute_at_ms,
  input  logic [31:0] last_send_ms,
  input  logic [7:0]  remaining_sends,
  input  logic        is_receiver,
  input  logic        already_started,
  input  logic [31:0] reference_ms,
  input  logic        last_event,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        feasible,
  output logic [1:0]  cause
);

  sfc_pkg::state_t state, state_next;

  logic        audio_mode;
  logic [15:0] window_ms;
  logic [9:0]  budget_audio;
  logic [9:0]  budget_no_audio;
  logic [15:0] early_lead_ms;
  logic [15:0] retry_gap_ms;
  logic [15:0] late_lead_ms;
  logic [7:0]  rx_limit;

  logic [sfc_pkg::CNT_W-1:0]     count;
  logic                          ovf;
  logic [sfc_pkg::CNT_W-1:0]     idx;
  logic [sfc_pkg::CNT_W-1:0]     first;
  logic [sfc_pkg::CNT_W-1:0]     jdx;
  sfc_pkg::entry_t               nw;
  logic                          nw_final;
  logic signed [31:0]            t_i;
  sfc_pkg::entry_t               w;
  logic signed [sfc_pkg::T_W-1:0] ready;
  logic                          ok;
  logic [sfc_pkg::CNT_W-1:0]     resident;
  logic                          have_rel;
  logic signed [sfc_pkg::T_W-1:0] rel;
  logic                          found;
  logic                          any;
  logic signed [sfc_pkg::T_W-1:0] best;
  logic [sfc_pkg::IDX_W-1:0]     pick;
  sfc_pkg::entry_t               pick_e;
  logic signed [sfc_pkg::T_W-1:0] next_tx;
  logic [sfc_pkg::NUM_W-1:0]     spacing;
  sfc_pkg::cause_t               res_cause;

  sfc_pkg::entry_t               rd;
  logic [sfc_pkg::IDX_W-1:0]     rd_addr;
  sfc_pkg::wr_req_t              wr;
  sfc_pkg::div_req_t             div_req;
  sfc_pkg::div_resp_t            div_resp;

  logic                          accept;
  logic                          fin_fire;
  logic [9:0]                    budget;
  logic                          ins_shift;
  logic signed [sfc_pkg::T_W-1:0] t_i_x;
  logic signed [sfc_pkg::T_W-1:0] rd_at_x;
  logic signed [sfc_pkg::T_W-1:0] win_diff;
  logic signed [sfc_pkg::T_W-1:0] win_len;
  logic                          win_adv;
  logic [sfc_pkg::CNT_W-1:0]     win_cnt;
  logic [10:0]                   win_cost;
  logic                          win_over;
  logic                          at_end;
  logic                          j_end;
  logic signed [sfc_pkg::T_W-1:0] w_at_x;
  logic signed [sfc_pkg::T_W-1:0] r0;
  logic signed [sfc_pkg::T_W-1:0] rt;
  logic signed [sfc_pkg::T_W-1:0] r1;
  logic signed [sfc_pkg::T_W-1:0] r2;
  logic                          w_started;
  logic                          w_probe;
  logic signed [sfc_pkg::T_W-1:0] rx_end;
  logic                          rx_hit;
  logic signed [sfc_pkg::T_W-1:0] latest;
  logic                          cand;
  logic signed [31:0]            in_at;
  logic signed [31:0]            in_last;

  sfc_store u_store (
    .clk     (clk),
    .wr      (wr),
    .rd_addr (rd_addr),
    .rd      (rd)
  );

  sfc_div u_div (
    .clk  (clk),
    .rst  (rst),
    .req  (div_req),
    .resp (div_resp)
  );

  assign in_at   = execute_at_ms - reference_ms;
  assign in_last = last_send_ms - reference_ms;

  assign accept   = in_valid && !in_stall;
  assign fin_fire = (state == sfc_pkg::ST_FIN) && (!out_valid || !out_stall);
  assign budget   = audio_mode ? budget_audio : budget_no_audio;

  assign ins_shift = (idx != '0) && (nw.at < rd.at);

  assign t_i_x    = {{2{t_i[31]}}, t_i};
  assign rd_at_x  = {{2{rd.at[31]}}, rd.at};
  assign win_diff = t_i_x - rd_at_x;
  assign win_len  = {{(sfc_pkg::T_W-16){1'b0}}, window_ms};
  assign win_adv  = (first < idx) && (win_diff >= win_len);
  assign win_cnt  = idx - first + sfc_pkg::CNT_W'(1);
  assign win_cost = 11'(win_cnt) * 11'(sfc_pkg::SEND_COST);
  assign win_over = win_cost > {1'b0, budget};
  assign at_end   = idx == count - sfc_pkg::CNT_W'(1);
  assign j_end    = jdx == count - sfc_pkg::CNT_W'(1);

  assign w_at_x    = {{2{w.at[31]}}, w.at};
  assign w_started = w.marks[1];
  assign w_probe   = !w.marks[1] && w.marks[0];
  assign r0        = w_at_x - {{(sfc_pkg::T_W-16){1'b0}}, early_lead_ms};
  assign rt        = w.last + {{(sfc_pkg::T_W-16){1'b0}}, retry_gap_ms};
  assign r1        = (w_started && (r0 < rt)) ? rt : r0;
  assign r2        = (r1 < next_tx) ? next_tx : r1;

  assign rx_end = rd_at_x + sfc_pkg::T_W'(sfc_pkg::RECEIVER_LATE);
  assign rx_hit = (rd.marks == 2'b11) && (rx_end >= ready);

  assign latest = w_at_x - {{(sfc_pkg::T_W-16){1'b0}}, late_lead_ms};
  assign cand   = ok && (ready <= latest) && (!found || (ready < best));

  // next state
  always_comb begin
    state_next = state;
    case (state)
      sfc_pkg::ST_IDLE: begin
        if (accept) begin
          if (count < sfc_pkg::CNT_W'(sfc_pkg::MAX_EVENTS)) begin
            state_next = sfc_pkg::ST_INS;
          end else if (last_event) begin
            state_next = sfc_pkg::ST_CHECK;
          end
        end
      end
      sfc_pkg::ST_INS: begin
        if (!ins_shift) begin
          state_next = nw_final ? sfc_pkg::ST_CHECK : sfc_pkg::ST_IDLE;
        end
      end
      sfc_pkg::ST_CHECK: begin
        if (ovf || budget == '0) begin
          state_next = sfc_pkg::ST_FIN;
        end else begin
          state_next = sfc_pkg::ST_WLOAD;
        end
      end
      sfc_pkg::ST_WLOAD: state_next = sfc_pkg::ST_WCMP;
      sfc_pkg::ST_WCMP: begin
        if (!win_adv) begin
          if (win_over) begin
            state_next = sfc_pkg::ST_FIN;
          end else if (at_end) begin
            state_next = sfc_pkg::ST_DIV_GO;
          end else begin
            state_next = sfc_pkg::ST_WLOAD;
          end
        end
      end
      sfc_pkg::ST_DIV_GO: state_next = sfc_pkg::ST_DIV_WAIT;
      sfc_pkg::ST_DIV_WAIT: begin
        if (div_resp.done) begin
          state_next = sfc_pkg::ST_SLOAD;
        end
      end
      sfc_pkg::ST_SLOAD: state_next = sfc_pkg::ST_READY;
      sfc_pkg::ST_READY: begin
        if (w.owed == '0) begin
          state_next = at_end ? sfc_pkg::ST_SEND : sfc_pkg::ST_SLOAD;
        end else if (w_probe) begin
          state_next = sfc_pkg::ST_RSTEP;
        end else begin
          state_next = sfc_pkg::ST_PICK;
        end
      end
      sfc_pkg::ST_RSTEP: begin
        if (j_end) begin
          state_next = sfc_pkg::ST_REND;
        end
      end
      sfc_pkg::ST_REND: state_next = sfc_pkg::ST_PICK;
      sfc_pkg::ST_PICK: state_next = at_end ? sfc_pkg::ST_SEND : sfc_pkg::ST_SLOAD;
      sfc_pkg::ST_SEND: begin
        if (!any || !found) begin
          state_next = sfc_pkg::ST_FIN;
        end else begin
          state_next = sfc_pkg::ST_SLOAD;
        end
      end
      sfc_pkg::ST_FIN: begin
        if (fin_fire) begin
          state_next = sfc_pkg::ST_IDLE;
        end
      end
      default: state_next = sfc_pkg::ST_IDLE;
    endcase
  end

  // outputs to store, divider and input side
  always_comb begin
    in_stall      = state != sfc_pkg::ST_IDLE;
    rd_addr       = idx[sfc_pkg::IDX_W-1:0];
    wr.en         = 1'b0;
    wr.addr       = idx[sfc_pkg::IDX_W-1:0];
    wr.data       = nw;
    div_req.start = 1'b0;
    div_req.num   = sfc_pkg::NUM_W'(window_ms) + sfc_pkg::NUM_W'(budget)
                    - sfc_pkg::NUM_W'(1);
    div_req.den   = budget;
    case (state)
      sfc_pkg::ST_INS: begin
        rd_addr = sfc_pkg::IDX_W'(idx - sfc_pkg::CNT_W'(1));
        wr.en   = 1'b1;
        wr.data = ins_shift ? rd : nw;
      end
      sfc_pkg::ST_WCMP:   rd_addr = first[sfc_pkg::IDX_W-1:0];
      sfc_pkg::ST_RSTEP:  rd_addr = jdx[sfc_pkg::IDX_W-1:0];
      sfc_pkg::ST_DIV_GO: div_req.start = 1'b1;
      sfc_pkg::ST_SEND: begin
        wr.en   = any && found;
        wr.addr = pick;
        wr.data = pick_e;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= sfc_pkg::ST_IDLE;
      count           <= '0;
      ovf             <= 1'b0;
      out_valid       <= 1'b0;
      audio_mode      <= 1'b0;
      window_ms       <= 16'd1000;
      budget_audio    <= 10'd10;
      budget_no_audio <= 10'd20;
      early_lead_ms   <= 16'd2000;
      retry_gap_ms    <= 16'd100;
      late_lead_ms    <= 16'd50;
      rx_limit        <= 8'd4;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        case (sfc_pkg::cfg_idx_t'(cfg_index))
          sfc_pkg::CFG_AUDIO_MODE:   audio_mode      <= cfg_data[0];
          sfc_pkg::CFG_WINDOW:       window_ms       <= cfg_data;
          sfc_pkg::CFG_BUDGET_AUDIO: budget_audio    <= cfg_data[9:0];
          sfc_pkg::CFG_BUDGET_NO:    budget_no_audio <= cfg_data[9:0];
          sfc_pkg::CFG_LOOKAHEAD:    early_lead_ms   <= cfg_data;
          sfc_pkg::CFG_RETRY:        retry_gap_ms    <= cfg_data;
          sfc_pkg::CFG_LAST_LEAD:    late_lead_ms    <= cfg_data;
          sfc_pkg::CFG_RX_BUDGET:    rx_limit        <= cfg_data[7:0];
          default: begin
          end
        endcase
      end
      if (accept && count == sfc_pkg::CNT_W'(sfc_pkg::MAX_EVENTS)) begin
        ovf <= 1'b1;
      end
      if (state == sfc_pkg::ST_INS && !ins_shift) begin
        count <= count + sfc_pkg::CNT_W'(1);
      end
      if (fin_fire) begin
        out_valid <= 1'b1;
        count     <= '0;
        ovf       <= 1'b0;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      sfc_pkg::ST_IDLE: begin
        if (accept) begin
          nw.at    <= in_at;
          nw.last  <= {{2{in_last[31]}}, in_last};
          nw.owed  <= remaining_sends;
          nw.marks <= {already_started, is_receiver};
          nw_final <= last_event;
          idx      <= count;
        end
      end
      sfc_pkg::ST_INS: begin
        if (ins_shift) begin
          idx <= idx - sfc_pkg::CNT_W'(1);
        end
      end
      sfc_pkg::ST_CHECK: begin
        idx   <= '0;
        first <= '0;
        if (ovf) begin
          res_cause <= sfc_pkg::CAUSE_FULL;
        end else begin
          res_cause <= sfc_pkg::CAUSE_WINDOW;
        end
      end
      sfc_pkg::ST_WLOAD: t_i <= rd.at;
      sfc_pkg::ST_WCMP: begin
        if (win_adv) begin
          first <= first + sfc_pkg::CNT_W'(1);
        end else if (!win_over) begin
          idx <= idx + sfc_pkg::CNT_W'(1);
        end
      end
      sfc_pkg::ST_DIV_WAIT: begin
        if (div_resp.done) begin
          spacing <= div_resp.quo;
          next_tx <= sfc_pkg::T_W'(div_resp.quo);
          idx     <= '0;
          found   <= 1'b0;
          any     <= 1'b0;
        end
      end
      sfc_pkg::ST_SLOAD: w <= rd;
      sfc_pkg::ST_READY: begin
        ready    <= r2;
        ok       <= 1'b1;
        jdx      <= '0;
        resident <= '0;
        have_rel <= 1'b0;
        if (w.owed == '0 && !at_end) begin
          idx <= idx + sfc_pkg::CNT_W'(1);
        end
      end
      sfc_pkg::ST_RSTEP: begin
        if (rx_hit) begin
          resident <= resident + sfc_pkg::CNT_W'(1);
          if (!have_rel || (rx_end + sfc_pkg::T_W'(1) < rel)) begin
            rel <= rx_end + sfc_pkg::T_W'(1);
          end
          have_rel <= 1'b1;
        end
        jdx <= jdx + sfc_pkg::CNT_W'(1);
      end
      sfc_pkg::ST_REND: begin
        if (8'(resident) >= rx_limit) begin
          if (have_rel) begin
            ready <= rel;
          end else begin
            ok <= 1'b0;
          end
        end
      end
      sfc_pkg::ST_PICK: begin
        any <= 1'b1;
        if (cand) begin
          found        <= 1'b1;
          best         <= ready;
          pick         <= idx[sfc_pkg::IDX_W-1:0];
          pick_e.at    <= w.at;
          pick_e.last  <= ready;
          pick_e.owed  <= w.owed - 8'd1;
          pick_e.marks <= w.marks | 2'b10;
        end
        if (!at_end) begin
          idx <= idx + sfc_pkg::CNT_W'(1);
        end
      end
      sfc_pkg::ST_SEND: begin
        if (!any) begin
          res_cause <= sfc_pkg::CAUSE_NONE;
        end else begin
          res_cause <= sfc_pkg::CAUSE_SLOT;
        end
        next_tx <= best + sfc_pkg::T_W'(spacing);
        idx     <= '0;
        found   <= 1'b0;
        any     <= 1'b0;
      end
      sfc_pkg::ST_FIN: begin
        if (fin_fire) begin
          feasible <= res_cause == sfc_pkg::CAUSE_NONE;
          cause    <= res_cause;
        end
      end
      default: begin
      end
    endcase
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= sfc_pkg::CNT_W'(sfc_pkg::MAX_EVENTS))
    else $error("store count beyond capacity");

  a_word_from_fin: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == sfc_pkg::ST_FIN)
    else $error("result word without finishing the check");

  a_feasible_cause: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (feasible == (cause == sfc_pkg::CAUSE_NONE)))
    else $error("feasible flag disagrees with cause");

  a_clear_after: assert property (@(posedge clk) disable iff (rst)
    fin_fire |=> (count == '0) && !ovf)
    else $error("store not cleared after result");

endmodule
